// File: design/sha256_byte_stream_hasher_core_defines.svh
// Assertion macros for the SHA-256 byte stream hasher.
// Used by the top level only; no other dependencies.
`ifndef SHA256_BYTE_STREAM_HASHER_CORE_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_CORE_DEFINES_SVH

// Implication that must hold at every clock edge outside reset.
`define SHA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked in the cycle after the antecedent.
`define SHA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/sha_pkg.sv
// Package for the SHA-256 byte stream hasher: round constants, initial hash
// values and the rotate and message schedule functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

   localparam int unsigned BlockBytes = 64;
   localparam int unsigned ByteAddrWidth = 6;
   localparam int unsigned WordAddrWidth = 4;
   localparam int unsigned CountWidth = 61;
   localparam int unsigned RoundWidth = 6;
   localparam logic [7:0] PadByte = 8'h80;
   localparam logic [5:0] LengthStart = 6'd56;

   localparam logic MODE_ABSORB = 1'b0;
   localparam logic MODE_FINISH = 1'b1;

   localparam logic [31:0] InitHash [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [31:0] RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   typedef logic [31:0] word_type;
   typedef word_type hash_type [8];

   // Control from the sequencer to the compression unit.
   typedef struct packed {
      logic start;
      logic sched_shift;
   } cmp_ctrl_type;

   function automatic word_type rotr(input word_type x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type sig0(input word_type x);
      sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type sig1(input word_type x);
      sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage
`default_nettype wire

// File: design/sha_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module sha_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] addr,
   input  wire logic [Width-1:0]         wr_data,
   output logic [Width-1:0]              rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// File: design/sha_compress.sv
// SHA-256 compression unit: one round per cycle while sched_shift is held,
// with a 16-word rolling message schedule. Depends on sha_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sha_compress (
   input  wire logic                      clock,
   input  wire sha_pkg::cmp_ctrl_type     ctrl,
   input  wire logic [sha_pkg::RoundWidth-1:0] round,
   input  wire sha_pkg::word_type         w_new,
   input  wire logic                      w_load,
   input  wire sha_pkg::hash_type         hash_in,
   output sha_pkg::hash_type              work_out
);
   sha_pkg::word_type sched_ff [16];
   sha_pkg::hash_type v_ff;
   sha_pkg::word_type t1, t2, ch, mj, s1e, s0a, w_cur, w_next;

   // Round word: the loaded word in the first 16 rounds, else the expansion.
   assign w_next = sha_pkg::sig1(sched_ff[14]) + sched_ff[9]
                   + sha_pkg::sig0(sched_ff[1]) + sched_ff[0];

   always_comb begin
      w_cur = w_load ? w_new : w_next;
      s1e = sha_pkg::rotr(v_ff[4], 6) ^ sha_pkg::rotr(v_ff[4], 11)
            ^ sha_pkg::rotr(v_ff[4], 25);
      s0a = sha_pkg::rotr(v_ff[0], 2) ^ sha_pkg::rotr(v_ff[0], 13)
            ^ sha_pkg::rotr(v_ff[0], 22);
      ch = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      mj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t1 = v_ff[7] + s1e + ch + sha_pkg::RoundK[round] + w_cur;
      t2 = s0a + mj;
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         v_ff <= hash_in;
      end else if (ctrl.sched_shift) begin
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
      if (ctrl.sched_shift) begin
         for (int i = 0; i < 15; i++) begin
            sched_ff[i] <= sched_ff[i+1];
         end
         sched_ff[15] <= w_cur;
      end
   end

   assign work_out = v_ff;
endmodule
`default_nettype wire

// File: design/sha256_byte_stream_hasher_core.sv
// Top level of the SHA-256 byte stream hasher: handshakes, block buffer
// memory, padding and round sequencer. Depends on sha_pkg, sha_ram,
// sha_compress and the assertion macro header.
//
//   Channel | Direction | Payload                              | Handshake
//   req     | in        | mode, data_byte                      | req_valid/req_ready
//   rsp     | out       | word_index, digest_word, last_word   | rsp_valid/rsp_ready
//
// An absorb request writes one byte into the 64-byte block memory. The
// sixty-fourth byte starts a compression: 16 word fetches of four byte
// reads and one round each, then 48 expansion rounds, then the chaining
// add. A finish request writes the 0x80 byte, then the rest of the padding
// one byte per cycle, plus one or two compressions, then offers eight
// digest words and restores the initial state. Reset clears control and
// the chaining values; the block memory needs no clearing because absorbs
// and padding together write every byte that a compression reads. A
// stalled result channel holds the block.
`timescale 1ns / 1ps
`default_nettype none
`include "sha256_byte_stream_hasher_core_defines.svh"
module sha256_byte_stream_hasher_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_mode,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_word_index,
   output logic [31:0]      rsp_digest_word,
   output logic             rsp_last_word
);
   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_PAD   = 7'b0000010,
      ST_LOAD  = 7'b0000100,
      ST_ROUND = 7'b0001000,
      ST_ADD   = 7'b0010000,
      ST_OUT   = 7'b0100000,
      ST_RESET = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [sha_pkg::CountWidth-1:0] count_ff, count_in;
   logic [5:0] pad_pos_ff, pad_pos_in;      // byte being padded
   logic       final_ff, final_in;          // this compression ends the message
   logic       two_ff, two_in;              // padding needs a second block
   logic [sha_pkg::RoundWidth-1:0] round_ff, round_in;
   logic [1:0] sub_ff, sub_in;              // byte lane within a word fetch
   logic       rd_pend_ff, rd_pend_in;      // read data returns this cycle
   logic [23:0] wacc_ff, wacc_in;
   logic [2:0] out_idx_ff, out_idx_in;
   sha_pkg::hash_type hash_ff;

   logic        mem_we;
   logic [5:0]  mem_addr;
   logic [7:0]  mem_wdata, mem_rdata;
   sha_pkg::cmp_ctrl_type ctrl;
   sha_pkg::hash_type work;
   logic        w_load;
   logic [63:0] bit_len;

   sha_ram #(.Width(8), .Depth(sha_pkg::BlockBytes)) u_buf (
      .clock  (clock),
      .wr_en  (mem_we),
      .addr   (mem_addr),
      .wr_data(mem_wdata),
      .rd_data(mem_rdata)
   );

   sha_compress u_cmp (
      .clock  (clock),
      .ctrl   (ctrl),
      .round  (round_ff),
      .w_new  ({wacc_ff, mem_rdata}),
      .w_load (w_load),
      .hash_in(hash_ff),
      .work_out(work)
   );

   assign bit_len = {count_ff, 3'b000};
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_word_index = out_idx_ff;
   assign rsp_digest_word = hash_ff[out_idx_ff];
   assign rsp_last_word = (out_idx_ff == 3'd7);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      pad_pos_in = pad_pos_ff;
      final_in = final_ff;
      two_in = two_ff;
      round_in = round_ff;
      sub_in = sub_ff;
      rd_pend_in = 1'b0;
      wacc_in = wacc_ff;
      out_idx_in = out_idx_ff;
      mem_we = 1'b0;
      mem_addr = count_ff[5:0];
      mem_wdata = req_data_byte;
      ctrl = '0;
      w_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_mode == sha_pkg::MODE_ABSORB) begin
                  mem_we = 1'b1;
                  count_in = count_ff + 1'b1;
                  if (count_ff[5:0] == 6'd63) begin
                     final_in = 1'b0;
                     state_in = ST_LOAD;
                     round_in = '0;
                     sub_in = '0;
                     ctrl.start = 1'b1;
                  end
               end else begin
                  mem_we = 1'b1;
                  mem_wdata = sha_pkg::PadByte;
                  pad_pos_in = count_ff[5:0] + 1'b1;
                  two_in = (count_ff[5:0] > 6'd55);
                  state_in = (count_ff[5:0] == 6'd63) ? ST_LOAD : ST_PAD;
                  final_in = !(count_ff[5:0] > 6'd55);
                  round_in = '0;
                  sub_in = '0;
                  ctrl.start = (count_ff[5:0] == 6'd63);
               end
            end
         end
         ST_PAD: begin
            mem_we = 1'b1;
            mem_addr = pad_pos_ff;
            if (!two_ff && pad_pos_ff >= sha_pkg::LengthStart) begin
               mem_wdata = bit_len[8*(7 - (pad_pos_ff - sha_pkg::LengthStart)) +: 8];
            end else begin
               mem_wdata = 8'h00;
            end
            pad_pos_in = pad_pos_ff + 1'b1;
            if (pad_pos_ff == 6'd63) begin
               state_in = ST_LOAD;
               round_in = '0;
               sub_in = '0;
               ctrl.start = 1'b1;
            end
         end
         ST_LOAD: begin
            // Fetch big-endian bytes of round word round_ff.
            mem_addr = {round_ff[3:0], sub_ff};
            rd_pend_in = 1'b1;
            if (rd_pend_ff) begin
               wacc_in = {wacc_ff[15:0], mem_rdata};
            end
            if (sub_ff == 2'd3) begin
               state_in = ST_ROUND;
            end
            sub_in = sub_ff + 1'b1;
         end
         ST_ROUND: begin
            ctrl.sched_shift = 1'b1;
            w_load = (round_ff < 6'd16);
            if (round_ff == 6'd63) begin
               state_in = ST_ADD;
            end else if (round_ff < 6'd15) begin
               state_in = ST_LOAD;
               wacc_in = '0;
            end
            round_in = round_ff + 1'b1;
         end
         ST_ADD: begin
            if (final_ff) begin
               state_in = ST_OUT;
               out_idx_in = '0;
            end else if (two_ff) begin
               two_in = 1'b0;
               final_in = 1'b1;
               pad_pos_in = '0;
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               out_idx_in = out_idx_ff + 1'b1;
               if (out_idx_ff == 3'd7) begin
                  state_in = ST_RESET;
               end
            end
         end
         ST_RESET: begin
            count_in = '0;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         out_idx_ff <= '0;
         two_ff <= 1'b0;
         final_ff <= 1'b0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         out_idx_ff <= out_idx_in;
         two_ff <= two_in;
         final_ff <= final_in;
         rd_pend_ff <= rd_pend_in;
      end
      pad_pos_ff <= pad_pos_in;
      round_ff <= round_in;
      sub_ff <= sub_in;
      wacc_ff <= wacc_in;
   end

   // Chaining values: initial on reset and after a digest, summed after a block.
   always_ff @(posedge clock) begin
      if (reset || state_ff == ST_RESET) begin
         hash_ff <= sha_pkg::InitHash;
      end else if (state_ff == ST_ADD) begin
         for (int i = 0; i < 8; i++) begin
            hash_ff[i] <= hash_ff[i] + work[i];
         end
      end
   end

   // The last fetched byte arrives in the round cycle straight from memory.
   `SHA_ASSERT_NEXT(a_load_to_round, clock, reset,
      state_ff == ST_LOAD && sub_ff == 2'd3, state_ff == ST_ROUND,
      "word fetch did not end in a round")
   `SHA_ASSERT_IMPL(a_no_req_busy, clock, reset,
      state_ff != ST_IDLE, !req_ready, "request accepted while busy")
   `SHA_ASSERT_IMPL(a_last_word, clock, reset,
      rsp_valid && rsp_last_word, out_idx_ff == 3'd7, "last word flag misplaced")
   `SHA_ASSERT_NEXT(a_reset_count, clock, reset,
      state_ff == ST_RESET, count_ff == '0, "count not cleared after digest")
endmodule
`default_nettype wire
